// ===== rtl/assert_macros.svh =====
// assertion macros shared by the ordered list table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, ignored while reset is held
`define OLT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never be seen at a rising edge
`define OLT_ASSERT_NEVER(lbl, cond, msg) \
  `OLT_ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/olt_pkg.sv =====
// types, codes and constants of the ordered list table
`timescale 1ns / 1ps
`default_nettype none

package olt_pkg;

  // default capacity and fixed field widths
  localparam int ENTRIES_DEF = 64;
  localparam int POS_W       = 7;
  localparam int KEY_W       = 16;
  localparam int PAY_W       = 48;

  // command codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_RSVD   = 2'd3
  } olt_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_MISS = 2'd3
  } olt_status_t;

  // input transaction
  typedef struct packed {
    logic [1:0]       opcode;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
  } olt_in_t;

  // result transaction
  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] found_position;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [POS_W-1:0] entry_total;
    logic             list_empty;
    logic             list_full;
  } olt_out_t;

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } olt_entry_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_CHK,
    S_DEL_WR,
    S_FND_CHK,
    S_FND_CMP
  } olt_state_t;

  // index counter operations
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_COUNT,
    IDX_LOAD_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } olt_idx_op_t;

  // read address select
  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1
  } olt_rd_sel_t;

  // write data select
  typedef enum logic {
    WD_RDATA,
    WD_NEW
  } olt_wd_sel_t;

  // entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } olt_cnt_op_t;

  // found position select
  typedef enum logic {
    FP_POS,
    FP_IDX
  } olt_fp_sel_t;

  // result entry select
  typedef enum logic [1:0] {
    RE_ZERO,
    RE_HOLD,
    RE_RDATA
  } olt_re_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load_req;
    olt_idx_op_t idx_op;
    logic        mem_re;
    olt_rd_sel_t rd_sel;
    logic        mem_we;
    olt_wd_sel_t wd_sel;
    logic        cap_en;
    olt_cnt_op_t cnt_op;
    logic        res_load;
    olt_status_t res_status;
    olt_fp_sel_t fp_sel;
    olt_re_sel_t re_sel;
  } olt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    olt_op_t opcode;
    logic    full;
    logic    pos_gt_cnt;
    logic    pos_ge_cnt;
    logic    idx_gt_pos;
    logic    idx_p1_lt_cnt;
    logic    idx_lt_cnt;
    logic    key_match;
    logic    out_busy;
  } olt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/olt_ctrl.sv =====
// controller state machine of the ordered list table
`timescale 1ns / 1ps
`default_nettype none

module olt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire olt_pkg::olt_sts_t sts,
  output olt_pkg::olt_cmd_t      cmd
);

  olt_pkg::olt_state_t state_r;
  olt_pkg::olt_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= olt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = olt_pkg::S_DISPATCH;
      end
      olt_pkg::S_DISPATCH: begin
        unique case (sts.opcode)
          olt_pkg::OP_INSERT: begin
            if (!sts.full && !sts.pos_gt_cnt) state_nxt = olt_pkg::S_INS_CHK;
            else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
          end
          olt_pkg::OP_DELETE: begin
            if (!sts.pos_ge_cnt) state_nxt = olt_pkg::S_DEL_RD;
            else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
          end
          olt_pkg::OP_FIND: state_nxt = olt_pkg::S_FND_CHK;
          default: begin
            if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
          end
        endcase
      end
      olt_pkg::S_INS_CHK: begin
        if (sts.idx_gt_pos) state_nxt = olt_pkg::S_INS_WR;
        else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
      end
      olt_pkg::S_INS_WR: state_nxt = olt_pkg::S_INS_CHK;
      olt_pkg::S_DEL_RD: state_nxt = olt_pkg::S_DEL_CAP;
      olt_pkg::S_DEL_CAP: state_nxt = olt_pkg::S_DEL_CHK;
      olt_pkg::S_DEL_CHK: begin
        if (sts.idx_p1_lt_cnt) state_nxt = olt_pkg::S_DEL_WR;
        else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
      end
      olt_pkg::S_DEL_WR: state_nxt = olt_pkg::S_DEL_CHK;
      olt_pkg::S_FND_CHK: begin
        if (sts.idx_lt_cnt) state_nxt = olt_pkg::S_FND_CMP;
        else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
      end
      olt_pkg::S_FND_CMP: begin
        if (!sts.key_match) state_nxt = olt_pkg::S_FND_CHK;
        else if (!sts.out_busy) state_nxt = olt_pkg::S_IDLE;
      end
      default: state_nxt = olt_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.idx_op     = olt_pkg::IDX_HOLD;
    cmd.rd_sel     = olt_pkg::RA_IDX;
    cmd.wd_sel     = olt_pkg::WD_RDATA;
    cmd.cnt_op     = olt_pkg::CNT_HOLD;
    cmd.res_status = olt_pkg::ST_OK;
    cmd.fp_sel     = olt_pkg::FP_POS;
    cmd.re_sel     = olt_pkg::RE_ZERO;
    unique case (state_r)
      olt_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      olt_pkg::S_DISPATCH: begin
        unique case (sts.opcode)
          olt_pkg::OP_INSERT: begin
            if (!sts.full && !sts.pos_gt_cnt) begin
              cmd.idx_op = olt_pkg::IDX_LOAD_COUNT;
            end else begin
              cmd.res_load   = !sts.out_busy;
              cmd.res_status = sts.full ? olt_pkg::ST_FULL : olt_pkg::ST_BAD;
            end
          end
          olt_pkg::OP_DELETE: begin
            if (!sts.pos_ge_cnt) begin
              cmd.idx_op = olt_pkg::IDX_LOAD_POS;
            end else begin
              cmd.res_load   = !sts.out_busy;
              cmd.res_status = olt_pkg::ST_BAD;
            end
          end
          olt_pkg::OP_FIND: cmd.idx_op = olt_pkg::IDX_ZERO;
          default: begin
            cmd.res_load   = !sts.out_busy;
            cmd.res_status = olt_pkg::ST_BAD;
          end
        endcase
      end
      olt_pkg::S_INS_CHK: begin
        if (sts.idx_gt_pos) begin
          cmd.mem_re = 1'b1;
          cmd.rd_sel = olt_pkg::RA_IDX_M1;
        end else if (!sts.out_busy) begin
          // place the new entry at the opened slot
          cmd.mem_we   = 1'b1;
          cmd.wd_sel   = olt_pkg::WD_NEW;
          cmd.cnt_op   = olt_pkg::CNT_INC;
          cmd.res_load = 1'b1;
        end
      end
      olt_pkg::S_INS_WR: begin
        cmd.mem_we = 1'b1;
        cmd.idx_op = olt_pkg::IDX_DEC;
      end
      olt_pkg::S_DEL_RD: cmd.mem_re = 1'b1;
      olt_pkg::S_DEL_CAP: cmd.cap_en = 1'b1;
      olt_pkg::S_DEL_CHK: begin
        if (sts.idx_p1_lt_cnt) begin
          cmd.mem_re = 1'b1;
          cmd.rd_sel = olt_pkg::RA_IDX_P1;
        end else if (!sts.out_busy) begin
          cmd.cnt_op   = olt_pkg::CNT_DEC;
          cmd.res_load = 1'b1;
          cmd.re_sel   = olt_pkg::RE_HOLD;
        end
      end
      olt_pkg::S_DEL_WR: begin
        cmd.mem_we = 1'b1;
        cmd.idx_op = olt_pkg::IDX_INC;
      end
      olt_pkg::S_FND_CHK: begin
        if (sts.idx_lt_cnt) begin
          cmd.mem_re = 1'b1;
        end else begin
          // miss: index has reached the count
          cmd.res_load   = !sts.out_busy;
          cmd.res_status = olt_pkg::ST_MISS;
          cmd.fp_sel     = olt_pkg::FP_IDX;
        end
      end
      olt_pkg::S_FND_CMP: begin
        if (!sts.key_match) begin
          cmd.idx_op = olt_pkg::IDX_INC;
        end else begin
          cmd.res_load = !sts.out_busy;
          cmd.fp_sel   = olt_pkg::FP_IDX;
          cmd.re_sel   = olt_pkg::RE_RDATA;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/olt_datapath.sv =====
// entry memory, counters, compares and result register of the ordered list table
`timescale 1ns / 1ps
`default_nettype none

module olt_datapath #(
  parameter int ENTRIES = olt_pkg::ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire olt_pkg::olt_in_t  in_data,
  input  wire olt_pkg::olt_cmd_t cmd,
  output olt_pkg::olt_sts_t      sts,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output olt_pkg::olt_out_t      out_data
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int AW   = $clog2(ENTRIES);
  localparam int PW   = olt_pkg::POS_W;
  localparam int CMPW = (CW > PW) ? CW : PW;

  olt_pkg::olt_entry_t mem_r [ENTRIES];

  olt_pkg::olt_in_t    req_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       idx_nxt;
  olt_pkg::olt_entry_t rdata_r;
  olt_pkg::olt_entry_t hold_r;
  olt_pkg::olt_out_t   out_r;
  olt_pkg::olt_out_t   out_nxt;
  logic                out_valid_r;

  logic [CW-1:0]       rd_idx;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  olt_pkg::olt_entry_t wr_data;
  olt_pkg::olt_entry_t res_entry;
  logic [CMPW-1:0]     pos_x;
  logic [CMPW-1:0]     cnt_x;
  logic [CMPW-1:0]     idx_x;
  logic [CW:0]         idx_p1;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= in_data;
  end

  // index counter
  always_comb begin
    unique case (cmd.idx_op)
      olt_pkg::IDX_HOLD:       idx_nxt = idx_r;
      olt_pkg::IDX_LOAD_COUNT: idx_nxt = cnt_r;
      olt_pkg::IDX_LOAD_POS:   idx_nxt = CW'(req_r.position);
      olt_pkg::IDX_ZERO:       idx_nxt = '0;
      olt_pkg::IDX_INC:        idx_nxt = idx_r + CW'(1);
      olt_pkg::IDX_DEC:        idx_nxt = idx_r - CW'(1);
      default:                 idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  // entry count
  always_comb begin
    unique case (cmd.cnt_op)
      olt_pkg::CNT_HOLD: cnt_nxt = cnt_r;
      olt_pkg::CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      olt_pkg::CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      default:           cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // memory addresses and write data
  always_comb begin
    unique case (cmd.rd_sel)
      olt_pkg::RA_IDX:    rd_idx = idx_r;
      olt_pkg::RA_IDX_M1: rd_idx = idx_r - CW'(1);
      olt_pkg::RA_IDX_P1: rd_idx = idx_r + CW'(1);
      default:            rd_idx = idx_r;
    endcase
  end

  assign rd_addr = rd_idx[AW-1:0];
  assign wr_addr = idx_r[AW-1:0];
  assign wr_data = (cmd.wd_sel == olt_pkg::WD_NEW)
                   ? {req_r.entry_key, req_r.entry_payload} : rdata_r;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem_r[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_re) rdata_r <= mem_r[rd_addr];
  end

  // removed entry hold
  always_ff @(posedge clk) begin
    if (cmd.cap_en) hold_r <= rdata_r;
  end

  // compares for the controller
  assign pos_x  = CMPW'(req_r.position);
  assign cnt_x  = CMPW'(cnt_r);
  assign idx_x  = CMPW'(idx_r);
  assign idx_p1 = {1'b0, idx_r} + {{CW{1'b0}}, 1'b1};

  always_comb begin
    sts               = '0;
    sts.opcode        = olt_pkg::olt_op_t'(req_r.opcode);
    sts.full          = (cnt_r == CW'(ENTRIES));
    sts.pos_gt_cnt    = (pos_x > cnt_x);
    sts.pos_ge_cnt    = (pos_x >= cnt_x);
    sts.idx_gt_pos    = (idx_x > pos_x);
    sts.idx_p1_lt_cnt = (idx_p1 < {1'b0, cnt_r});
    sts.idx_lt_cnt    = (idx_r < cnt_r);
    sts.key_match     = (rdata_r.key == req_r.entry_key);
    sts.out_busy      = out_valid_r && !out_ready;
  end

  // result assembly
  always_comb begin
    unique case (cmd.re_sel)
      olt_pkg::RE_ZERO:  res_entry = '0;
      olt_pkg::RE_HOLD:  res_entry = hold_r;
      olt_pkg::RE_RDATA: res_entry = rdata_r;
      default:           res_entry = '0;
    endcase
    out_nxt                = '0;
    out_nxt.status         = cmd.res_status;
    out_nxt.found_position = (cmd.fp_sel == olt_pkg::FP_IDX) ? PW'(idx_r) : req_r.position;
    out_nxt.out_key        = res_entry.key;
    out_nxt.out_payload    = res_entry.payload;
    out_nxt.entry_total    = PW'(cnt_nxt);
    out_nxt.list_empty     = (cnt_nxt == '0);
    out_nxt.list_full      = (cnt_nxt == CW'(ENTRIES));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_table.sv =====
// ordered list table: top level joining controller and datapath
// Usage:
//   A bounded ordered list of up to ENTRIES key/payload entries. Commands
//   arrive on the in_ channel (valid/ready), one transaction per command,
//   and each yields exactly one result transaction on the out_ channel.
//   Commands: insert at index, delete at index (returns the entry), find
//   the lowest index holding a key. Results carry status, position, the
//   entry, the count after the command and empty/full flags.
// in_ready returns in the cycle after the result is loaded. Every shifted
// or searched entry takes a registered read on the single read port of the
// entry memory, then a compare or a write back.
// One command is in progress at a time. A finished result waits in the
// output register while the next command is taken and worked on; a command
// only holds before loading its result when that register is still unread.
// Reset empties the list; entry contents are never read before written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_list_table #(
  parameter int ENTRIES = olt_pkg::ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire olt_pkg::olt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output olt_pkg::olt_out_t     out_data
);

  olt_pkg::olt_cmd_t cmd;
  olt_pkg::olt_sts_t sts;

  // sequencing
  olt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  olt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `OLT_ASSERT_CLK(a_accept_drops_ready, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `OLT_ASSERT_CLK(a_result_shows, cmd.res_load |=> out_valid, "loaded result not shown")
  `OLT_ASSERT_NEVER(a_no_overwrite, cmd.res_load && out_valid && !out_ready, "unread result lost")
  `OLT_ASSERT_CLK(a_full_flag, (out_valid && out_data.status == olt_pkg::ST_FULL) |-> out_data.list_full, "full status without full flag")

endmodule

`default_nettype wire
